// ----- hw/rtl/ctoc_pkg.sv -----
package ctoc_pkg;

    localparam int CMD_W = 32;

    // compensation modes
    localparam logic [2:0] MODE_NONE      = 3'd0;
    localparam logic [2:0] MODE_RAD_LEFT  = 3'd1;
    localparam logic [2:0] MODE_RAD_RIGHT = 3'd2;
    localparam logic [2:0] MODE_LEN_POS   = 3'd3;
    localparam logic [2:0] MODE_LEN_NEG   = 3'd4;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_COMP_MODE   = 3'd0;
    localparam logic [2:0] REG_TOOL_RADIUS = 3'd1;
    localparam logic [2:0] REG_RADIUS_WEAR = 3'd2;
    localparam logic [2:0] REG_TOOL_LENGTH = 3'd3;
    localparam logic [2:0] REG_LENGTH_WEAR = 3'd4;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    typedef struct packed {
        logic signed [CMD_W-1:0] target_x;
        logic signed [CMD_W-1:0] target_y;
        logic signed [CMD_W-1:0] target_z;
        logic signed [CMD_W-1:0] current_x;
        logic signed [CMD_W-1:0] current_y;
    } t_cmd;

    typedef struct packed {
        logic signed [CMD_W-1:0] out_x;
        logic signed [CMD_W-1:0] out_y;
        logic signed [CMD_W-1:0] out_z;
    } t_res;

    // data that rides along the root and divide stages
    typedef struct packed {
        logic signed [CMD_W-1:0] tx;
        logic signed [CMD_W-1:0] ty;
        logic signed [CMD_W-1:0] tz;
        logic                    sdx;
        logic                    sdy;
        logic                    zero;
        logic [30:0]             sx;
        logic [30:0]             sy;
    } t_side;

endpackage

// ----- hw/rtl/cnc_tool_offset_compensation_unit.sv -----
// Cutter radius and tool length compensation of one move per transaction.
// Command channel: i_cmd carries target X/Y/Z and current X/Y (signed Q16.16).
// A transaction is taken at a rising edge with start high and busy low; busy
// stays low, so a new move may be issued in every cycle.
// Result channel: o_res carries compensated X/Y/Z, saturated to 32 bits, valid
// for exactly one cycle while o_done is high. Results leave in issue order.
// Pipeline: the 32-stage square root and the 31-stage restoring divider (one
// result bit per stage), plus seven stages of difference, normalize and square
// ahead of them and four stages of divider setup, multiply, round and saturate
// after them. Throughput: one move per cycle.
// Configuration: APB registers at byte addresses 0x00 comp_mode,
// 0x04 tool_radius, 0x08 radius_wear, 0x0C tool_length, 0x10 length_wear.
// Write them only while no move is in flight. pready is always high.
// Reset (synchronous, active low) clears the configuration registers to zero
// and empties the pipeline. The receiver has no way to stall; it must take each
// result in the cycle it is shown.
module cnc_tool_offset_compensation_unit
    import ctoc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,
    output logic        o_done,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    function automatic logic [4:0] lzc31(input logic [30:0] v);
        logic [4:0] c;
        logic       found;
        c     = 5'd31;
        found = 1'b0;
        for (int i = 30; i >= 0; i--) begin
            if (!found && v[i]) begin
                c     = 5'(30 - i);
                found = 1'b1;
            end
        end
        return c;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    // ---------------- configuration ----------------
    logic [2:0]         r_comp_mode;
    logic signed [23:0] r_tool_radius;
    logic signed [23:0] r_radius_wear;
    logic signed [26:0] r_tool_length;
    logic signed [26:0] r_length_wear;
    logic               w_wr;
    logic [2:0]         w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp_mode   <= MODE_NONE;
            r_tool_radius <= '0;
            r_radius_wear <= '0;
            r_tool_length <= '0;
            r_length_wear <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_COMP_MODE:   r_comp_mode   <= pwdata[2:0];
                REG_TOOL_RADIUS: r_tool_radius <= pwdata[23:0];
                REG_RADIUS_WEAR: r_radius_wear <= pwdata[23:0];
                REG_TOOL_LENGTH: r_tool_length <= pwdata[26:0];
                REG_LENGTH_WEAR: r_length_wear <= pwdata[26:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_COMP_MODE:   prdata = {29'd0, r_comp_mode};
            REG_TOOL_RADIUS: prdata = 32'(r_tool_radius);
            REG_RADIUS_WEAR: prdata = 32'(r_radius_wear);
            REG_TOOL_LENGTH: prdata = 32'(r_tool_length);
            REG_LENGTH_WEAR: prdata = 32'(r_length_wear);
            default:         prdata = '0;
        endcase
    end

    // combined radius and length, registered off the config path
    logic signed [24:0] w_rad;
    logic               r_rad_neg;
    logic [24:0]        r_rad_abs;
    logic signed [27:0] r_len_sum;

    assign w_rad = 25'(r_tool_radius) + 25'(r_radius_wear);

    always_ff @(posedge i_clk) begin
        r_rad_neg <= w_rad[24];
        r_rad_abs <= w_rad[24] ? 25'(-w_rad) : w_rad;
        r_len_sum <= 28'(r_tool_length) + 28'(r_length_wear);
    end

    // ---------------- front: difference, abs, normalize, square ----------------
    logic               r_a_vld;
    t_cmd               r_a_cmd;
    logic               r_b_vld;
    logic signed [32:0] r_b_dx, r_b_dy;
    logic signed [31:0] r_b_tx, r_b_ty, r_b_tz;
    logic               r_c_vld;
    logic [31:0]        r_c_ax, r_c_ay;
    logic               r_c_sdx, r_c_sdy, r_c_zero;
    logic signed [31:0] r_c_tx, r_c_ty, r_c_tz;
    logic               r_d_vld;
    logic [31:0]        r_d_ax, r_d_ay;
    logic               r_d_right;
    logic [4:0]         r_d_sh;
    logic               r_d_sdx, r_d_sdy, r_d_zero;
    logic signed [31:0] r_d_tx, r_d_ty, r_d_tz;
    logic               r_e_vld;
    t_side              r_e_side;
    logic               r_f_vld;
    t_side              r_f_side;
    logic [61:0]        r_f_px, r_f_py;
    logic               r_g_vld;
    t_side              r_g_side;
    logic [62:0]        r_g_sum;
    logic [31:0]        w_c_m;

    assign w_c_m = (r_c_ax > r_c_ay) ? r_c_ax : r_c_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_cmd <= i_cmd;

        r_b_dx <= 33'(r_a_cmd.target_x) - 33'(r_a_cmd.current_x);
        r_b_dy <= 33'(r_a_cmd.target_y) - 33'(r_a_cmd.current_y);
        r_b_tx <= r_a_cmd.target_x;
        r_b_ty <= r_a_cmd.target_y;
        r_b_tz <= r_a_cmd.target_z;

        r_c_ax   <= r_b_dx[32] ? 32'(-r_b_dx) : r_b_dx[31:0];
        r_c_ay   <= r_b_dy[32] ? 32'(-r_b_dy) : r_b_dy[31:0];
        r_c_sdx  <= r_b_dx[32];
        r_c_sdy  <= r_b_dy[32];
        r_c_zero <= (r_b_dx == '0) && (r_b_dy == '0);
        r_c_tx   <= r_b_tx;
        r_c_ty   <= r_b_ty;
        r_c_tz   <= r_b_tz;

        r_d_ax    <= r_c_ax;
        r_d_ay    <= r_c_ay;
        r_d_right <= w_c_m[31];
        r_d_sh    <= lzc31(w_c_m[30:0]);
        r_d_sdx   <= r_c_sdx;
        r_d_sdy   <= r_c_sdy;
        r_d_zero  <= r_c_zero;
        r_d_tx    <= r_c_tx;
        r_d_ty    <= r_c_ty;
        r_d_tz    <= r_c_tz;

        r_e_side.tx   <= r_d_tx;
        r_e_side.ty   <= r_d_ty;
        r_e_side.tz   <= r_d_tz;
        r_e_side.sdx  <= r_d_sdx;
        r_e_side.sdy  <= r_d_sdy;
        r_e_side.zero <= r_d_zero;
        r_e_side.sx   <= r_d_right ? r_d_ax[31:1] : 31'(r_d_ax << r_d_sh);
        r_e_side.sy   <= r_d_right ? r_d_ay[31:1] : 31'(r_d_ay << r_d_sh);

        r_f_side <= r_e_side;
        r_f_px   <= 62'(r_e_side.sx) * 62'(r_e_side.sx);
        r_f_py   <= 62'(r_e_side.sy) * 62'(r_e_side.sy);

        r_g_side <= r_f_side;
        r_g_sum  <= 63'(r_f_px) + 63'(r_f_py);
    end

    // ---------------- square root, one result bit per stage ----------------
    logic        r_sq_vld  [SQRT_STEPS];
    t_side       r_sq_side [SQRT_STEPS];
    logic [62:0] r_sq_n    [SQRT_STEPS];
    logic [62:0] r_sq_res  [SQRT_STEPS];
    logic [62:0] n_sq_n    [SQRT_STEPS];
    logic [62:0] n_sq_res  [SQRT_STEPS];

    always_comb begin
        logic [62:0] v_n;
        logic [62:0] v_res;
        logic [62:0] v_bit;
        logic [63:0] v_trial;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            v_n     = (k == 0) ? r_g_sum : r_sq_n[(k == 0) ? 0 : k - 1];
            v_res   = (k == 0) ? '0 : r_sq_res[(k == 0) ? 0 : k - 1];
            v_bit   = 63'(1) << (62 - 2 * k);
            v_trial = {1'b0, v_res} + {1'b0, v_bit};
            if ({1'b0, v_n} >= v_trial) begin
                n_sq_n[k]   = v_n - v_trial[62:0];
                n_sq_res[k] = (v_res >> 1) + v_bit;
            end else begin
                n_sq_n[k]   = v_n;
                n_sq_res[k] = v_res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_sq_vld[k] <= 1'b0;
            end
        end else begin
            r_sq_vld[0] <= r_g_vld;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_sq_vld[k] <= r_sq_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_side[0] <= r_g_side;
        for (int k = 1; k < SQRT_STEPS; k++) begin
            r_sq_side[k] <= r_sq_side[k-1];
        end
        for (int k = 0; k < SQRT_STEPS; k++) begin
            r_sq_n[k]   <= n_sq_n[k];
            r_sq_res[k] <= n_sq_res[k];
        end
    end

    // ---------------- divider setup: (a << 30 + len/2) / len ----------------
    logic        r_h_vld;
    t_side       r_h_side;
    logic [31:0] r_h_len;
    logic [31:0] r_h_remx, r_h_remy;
    logic [30:0] r_h_lowx, r_h_lowy;
    logic [31:0] w_len;
    logic [61:0] w_numx, w_numy;

    assign w_len  = r_sq_res[SQRT_STEPS-1][31:0];
    assign w_numx = (62'(r_sq_side[SQRT_STEPS-1].sx) << 30) + 62'(w_len[31:1]);
    assign w_numy = (62'(r_sq_side[SQRT_STEPS-1].sy) << 30) + 62'(w_len[31:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= r_sq_vld[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_side <= r_sq_side[SQRT_STEPS-1];
        r_h_len  <= w_len;
        r_h_remx <= {1'b0, w_numx[61:31]};
        r_h_remy <= {1'b0, w_numy[61:31]};
        r_h_lowx <= w_numx[30:0];
        r_h_lowy <= w_numy[30:0];
    end

    // ---------------- restoring dividers, one quotient bit per stage ----------------
    logic        r_dv_vld  [DIV_STEPS];
    t_side       r_dv_side [DIV_STEPS];
    logic [31:0] r_dv_len  [DIV_STEPS];
    logic [31:0] r_dv_remx [DIV_STEPS];
    logic [31:0] r_dv_remy [DIV_STEPS];
    logic [30:0] r_dv_lowx [DIV_STEPS];
    logic [30:0] r_dv_lowy [DIV_STEPS];
    logic [30:0] r_dv_qx   [DIV_STEPS];
    logic [30:0] r_dv_qy   [DIV_STEPS];
    logic [31:0] n_dv_remx [DIV_STEPS];
    logic [31:0] n_dv_remy [DIV_STEPS];
    logic [30:0] n_dv_qx   [DIV_STEPS];
    logic [30:0] n_dv_qy   [DIV_STEPS];

    always_comb begin
        logic [31:0] v_len;
        logic [32:0] v_tx;
        logic [32:0] v_ty;
        logic [30:0] v_qx;
        logic [30:0] v_qy;
        logic        v_gx;
        logic        v_gy;
        for (int j = 0; j < DIV_STEPS; j++) begin
            v_len = (j == 0) ? r_h_len : r_dv_len[(j == 0) ? 0 : j - 1];
            v_tx  = (j == 0) ? {r_h_remx, r_h_lowx[30]}
                             : {r_dv_remx[(j == 0) ? 0 : j - 1],
                                r_dv_lowx[(j == 0) ? 0 : j - 1][30]};
            v_ty  = (j == 0) ? {r_h_remy, r_h_lowy[30]}
                             : {r_dv_remy[(j == 0) ? 0 : j - 1],
                                r_dv_lowy[(j == 0) ? 0 : j - 1][30]};
            v_qx  = (j == 0) ? '0 : r_dv_qx[(j == 0) ? 0 : j - 1];
            v_qy  = (j == 0) ? '0 : r_dv_qy[(j == 0) ? 0 : j - 1];
            v_gx  = v_tx >= {1'b0, v_len};
            v_gy  = v_ty >= {1'b0, v_len};
            n_dv_remx[j] = v_gx ? 32'(v_tx - {1'b0, v_len}) : v_tx[31:0];
            n_dv_remy[j] = v_gy ? 32'(v_ty - {1'b0, v_len}) : v_ty[31:0];
            n_dv_qx[j]   = {v_qx[29:0], v_gx};
            n_dv_qy[j]   = {v_qy[29:0], v_gy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_dv_vld[j] <= 1'b0;
            end
        end else begin
            r_dv_vld[0] <= r_h_vld;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_dv_vld[j] <= r_dv_vld[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_side[0] <= r_h_side;
        r_dv_len[0]  <= r_h_len;
        r_dv_lowx[0] <= {r_h_lowx[29:0], 1'b0};
        r_dv_lowy[0] <= {r_h_lowy[29:0], 1'b0};
        for (int j = 1; j < DIV_STEPS; j++) begin
            r_dv_side[j] <= r_dv_side[j-1];
            r_dv_len[j]  <= r_dv_len[j-1];
            r_dv_lowx[j] <= {r_dv_lowx[j-1][29:0], 1'b0};
            r_dv_lowy[j] <= {r_dv_lowy[j-1][29:0], 1'b0};
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
            r_dv_remx[j] <= n_dv_remx[j];
            r_dv_remy[j] <= n_dv_remy[j];
            r_dv_qx[j]   <= n_dv_qx[j];
            r_dv_qy[j]   <= n_dv_qy[j];
        end
    end

    // ---------------- scale, round, sign, add ----------------
    logic               r_m_vld;
    t_side              r_m_side;
    logic [55:0]        r_m_prodx, r_m_prody;
    logic               r_n_vld;
    t_side              r_n_side;
    logic signed [26:0] r_n_ofx, r_n_ofy;
    logic signed [28:0] r_n_ofz;
    logic               r_o_vld;
    t_res               r_o_res;
    logic [55:0]        w_rndx, w_rndy;
    logic [25:0]        w_magx, w_magy;
    logic               w_left, w_radial, w_negx, w_negy;
    logic signed [26:0] w_ofx, w_ofy;
    logic signed [28:0] w_ofz;

    assign w_rndx   = r_m_prodx + (56'(1) << 29);
    assign w_rndy   = r_m_prody + (56'(1) << 29);
    assign w_magx   = w_rndx[55:30];
    assign w_magy   = w_rndy[55:30];
    assign w_left   = (r_comp_mode == MODE_RAD_LEFT);
    assign w_radial = ((r_comp_mode == MODE_RAD_LEFT) || (r_comp_mode == MODE_RAD_RIGHT))
                      && !r_m_side.zero;
    // left of travel is (-dy, dx), right is (dy, -dx); a negative radius flips both
    assign w_negx   = r_m_side.sdy ^ w_left ^ r_rad_neg;
    assign w_negy   = r_m_side.sdx ^ !w_left ^ r_rad_neg;

    always_comb begin
        w_ofx = '0;
        w_ofy = '0;
        if (w_radial) begin
            w_ofx = w_negx ? -$signed({1'b0, w_magx}) : $signed({1'b0, w_magx});
            w_ofy = w_negy ? -$signed({1'b0, w_magy}) : $signed({1'b0, w_magy});
        end
        case (r_comp_mode)
            MODE_LEN_POS: w_ofz = 29'(r_len_sum);
            MODE_LEN_NEG: w_ofz = -29'(r_len_sum);
            default:      w_ofz = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_n_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_m_vld <= r_dv_vld[DIV_STEPS-1];
            r_n_vld <= r_m_vld;
            r_o_vld <= r_n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_side  <= r_dv_side[DIV_STEPS-1];
        // uy scales the X offset, ux the Y offset
        r_m_prodx <= 56'(r_dv_qy[DIV_STEPS-1]) * 56'(r_rad_abs);
        r_m_prody <= 56'(r_dv_qx[DIV_STEPS-1]) * 56'(r_rad_abs);

        r_n_side <= r_m_side;
        r_n_ofx  <= w_ofx;
        r_n_ofy  <= w_ofy;
        r_n_ofz  <= w_ofz;

        r_o_res.out_x <= sat32(34'(r_n_side.tx) + 34'(r_n_ofx));
        r_o_res.out_y <= sat32(34'(r_n_side.ty) + 34'(r_n_ofy));
        r_o_res.out_z <= sat32(34'(r_n_side.tz) + 34'(r_n_ofz));
    end

    assign o_done = r_o_vld;
    assign o_res  = r_o_res;

    // ---------------- checks ----------------
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_vld && !r_e_side.zero |-> (r_e_side.sx[30] || r_e_side.sy[30]))
        else $error("normalized move direction out of range");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_h_vld && !r_h_side.zero |-> (r_h_len[31:30] != 2'b00))
        else $error("root of a nonzero move below 2^30");

    a_unit_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[DIV_STEPS-1] && !r_dv_side[DIV_STEPS-1].zero
            && r_dv_qx[DIV_STEPS-1][30] |->
            (r_dv_qx[DIV_STEPS-1][29:0] == '0))
        else $error("unit component above one");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_done)
        else $error("result strobe right after reset");

endmodule
